// ----- sv/tsbms_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbms_pkg
// Shared types and constants for the three-step block motion search.
// ----------------------------------------------------------------------------
package tsbms_pkg;

  localparam int BLOCK_SIZE_DEF  = 16;
  localparam int FIRST_STEP_DEF  = 4;
  localparam int WINDOW_SIDE_DEF = 32;

  localparam int OP_W      = 2;
  localparam int POS_W     = 5;
  localparam int PIX_W     = 8;
  localparam int ORG_W     = 12;
  localparam int DIM_W     = 13;
  localparam int VEC_W     = 4;
  localparam int SAD_W     = 16;
  localparam int CFG_IDX_W = 2;
  // signed width for window coordinates and clamp bounds
  localparam int COORD_W   = 15;

  localparam logic [DIM_W-1:0] FRAME_W_RESET = 13'd1920;
  localparam logic [DIM_W-1:0] FRAME_H_RESET = 13'd1080;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_CUR = 2'd0,
    OP_LOAD_REF = 2'd1,
    OP_START    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] pixel;
    logic [ORG_W-1:0] block_x;
    logic [ORG_W-1:0] block_y;
  } in_word_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] best_dx;
    logic signed [VEC_W-1:0] best_dy;
    logic [SAD_W-1:0]        min_sad;
  } out_word_t;

endpackage

// ----- sv/three_step_block_motion_search.sv -----
// ----------------------------------------------------------------------------
// three_step_block_motion_search
// Three-step SAD block matching over a loaded block and reference window.
// ----------------------------------------------------------------------------
//  channel | ports                                   | carries
//  --------+-----------------------------------------+------------------------
//  in      | in_valid  in_ready  in_data             | pixel loads and start
//  out     | out_valid out_ready out_data            | best vector and SAD
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data  | frame width / height
//
//  A start scores 1 + 8 * (number of steps) vectors, 25 by default (none if
//  the block lies outside the frame), each over bw * bh pixels at one pixel
//  a cycle, then drains the pipeline and compares; the search's pace is set
//  by the single SAD datapath and the window read port. in_ready is low from
//  a start until its word is handed to the output register. Reset is
//  synchronous; block and window memories are not cleared. The config port
//  is always ready.
// ----------------------------------------------------------------------------
module three_step_block_motion_search #(
  parameter int BLOCK_SIZE  = tsbms_pkg::BLOCK_SIZE_DEF,
  parameter int FIRST_STEP  = tsbms_pkg::FIRST_STEP_DEF,
  parameter int WINDOW_SIDE = tsbms_pkg::WINDOW_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsbms_pkg::in_word_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsbms_pkg::out_word_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsbms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsbms_pkg::DIM_W-1:0]         cfg_data
);
  import tsbms_pkg::*;

  localparam int REACH = 2 * FIRST_STEP - 1;
  localparam int DW    = $clog2(2 * FIRST_STEP) + 1;
  localparam int SPW   = $clog2(FIRST_STEP + 1);
  localparam int RCW   = $clog2(BLOCK_SIZE);
  localparam int BWW   = $clog2(BLOCK_SIZE + 1);
  localparam int CAW   = $clog2(BLOCK_SIZE * BLOCK_SIZE);
  localparam int WAW   = $clog2(WINDOW_SIDE * WINDOW_SIDE);
  localparam int ACW   = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);
  localparam int CW    = COORD_W;
  localparam logic [ACW-1:0] SAD_SAT = ACW'((1 << SAD_W) - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // neighbour order: row-major around the centre, centre skipped
  function automatic logic signed [1:0] nb_x(input logic [2:0] nb);
    logic signed [1:0] v;
    case (nb)
      3'd0, 3'd3, 3'd5: v = -2'sd1;
      3'd1, 3'd6:       v = 2'sd0;
      default:          v = 2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] nb_y(input logic [2:0] nb);
    logic signed [1:0] v;
    case (nb)
      3'd0, 3'd1, 3'd2: v = -2'sd1;
      3'd3, 3'd4:       v = 2'sd0;
      default:          v = 2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] offs(input logic signed [1:0] n,
                                                 input logic [SPW-1:0] st);
    logic signed [DW-1:0] v;
    if (n < 0) begin
      v = DW'(0) - DW'(st);
    end else if (n > 0) begin
      v = DW'(st);
    end else begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                   input logic signed [CW-1:0] lo,
                                                   input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // control registers
  state_t                state_r, state_nxt;
  logic [DIM_W-1:0]      frame_w_r, frame_w_nxt;
  logic [DIM_W-1:0]      frame_h_r, frame_h_nxt;
  logic signed [CW-1:0]  lo_x_r, lo_x_nxt, hi_x_r, hi_x_nxt;
  logic signed [CW-1:0]  lo_y_r, lo_y_nxt, hi_y_r, hi_y_nxt;
  logic [BWW-1:0]        bw_r, bw_nxt, bh_r, bh_nxt;
  logic [RCW-1:0]        col_cnt_r, col_cnt_nxt, row_cnt_r, row_cnt_nxt;
  logic signed [DW-1:0]  cand_dx_r, cand_dx_nxt, cand_dy_r, cand_dy_nxt;
  logic signed [DW-1:0]  ctr_dx_r, ctr_dx_nxt, ctr_dy_r, ctr_dy_nxt;
  logic signed [DW-1:0]  best_dx_r, best_dx_nxt, best_dy_r, best_dy_nxt;
  logic [ACW-1:0]        min_sad_r, min_sad_nxt;
  logic                  first_r, first_nxt;
  logic [SPW-1:0]        step_r, step_nxt;
  logic [2:0]            nb_r, nb_nxt;
  logic [ACW-1:0]        acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  // SAD pipeline
  logic                  s1_v_r, s2_v_r, s2_ok_r;
  logic signed [CW-1:0]  s1_tx_r, s1_ty_r;
  logic [CAW-1:0]        s1_caddr_r;
  logic [PIX_W-1:0]      cur_q_r, win_q_r;

  logic [PIX_W-1:0]      cur_mem [BLOCK_SIZE*BLOCK_SIZE];
  logic [PIX_W-1:0]      win_mem [WINDOW_SIDE*WINDOW_SIDE];

  logic                  in_acc;
  logic                  cur_we, win_we;
  logic [CAW-1:0]        cur_waddr;
  logic [WAW-1:0]        win_waddr, win_raddr;
  logic signed [CW-1:0]  tx_s, ty_s, wc_s, wr_s;
  logic                  win_ok;
  logic [PIX_W-1:0]      ref_pix, absd;
  logic signed [CW-1:0]  dx_diff, dy_diff;
  logic                  better;
  logic signed [DW-1:0]  nb_best_dx, nb_best_dy;
  logic                  last_col, last_row;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign in_acc    = in_valid && in_ready;

  // loads
  assign cur_we    = in_acc && (in_data.op == OP_LOAD_CUR) &&
                     (int'(in_data.col) < BLOCK_SIZE) && (int'(in_data.row) < BLOCK_SIZE);
  assign win_we    = in_acc && (in_data.op == OP_LOAD_REF) &&
                     (int'(in_data.col) < WINDOW_SIDE) && (int'(in_data.row) < WINDOW_SIDE);
  assign cur_waddr = CAW'(int'(in_data.row) * BLOCK_SIZE + int'(in_data.col));
  assign win_waddr = WAW'(int'(in_data.row) * WINDOW_SIDE + int'(in_data.col));

  // stage 1: raw window coordinates
  assign tx_s = CW'(col_cnt_r) - CW'(cand_dx_r) + CW'(REACH);
  assign ty_s = CW'(row_cnt_r) - CW'(cand_dy_r) + CW'(REACH);

  // stage 2: clamp to frame, window address
  assign wc_s   = clampc(s1_tx_r, lo_x_r, hi_x_r);
  assign wr_s   = clampc(s1_ty_r, lo_y_r, hi_y_r);
  assign win_ok = (wc_s >= 0) && (wc_s < $signed(CW'(WINDOW_SIDE))) &&
                  (wr_s >= 0) && (wr_s < $signed(CW'(WINDOW_SIDE)));
  assign win_raddr = win_ok ? WAW'(wr_s * WINDOW_SIDE + wc_s) : '0;

  // stage 3: absolute difference
  assign ref_pix = s2_ok_r ? win_q_r : '0;
  assign absd    = (cur_q_r >= ref_pix) ? (cur_q_r - ref_pix) : (ref_pix - cur_q_r);

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= in_data.pixel;
    end
    cur_q_r <= cur_mem[s1_caddr_r];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= in_data.pixel;
    end
    win_q_r <= win_mem[win_raddr];
  end

  assign dx_diff  = CW'(frame_w_r) - CW'(in_data.block_x);
  assign dy_diff  = CW'(frame_h_r) - CW'(in_data.block_y);
  assign last_col = ((BWW'(col_cnt_r) + 1'b1) == bw_r);
  assign last_row = ((BWW'(row_cnt_r) + 1'b1) == bh_r);
  assign better   = first_r || (acc_r < min_sad_r);
  assign nb_best_dx = better ? cand_dx_r : best_dx_r;
  assign nb_best_dy = better ? cand_dy_r : best_dy_r;

  always_comb begin
    state_nxt     = state_r;
    frame_w_nxt   = frame_w_r;
    frame_h_nxt   = frame_h_r;
    lo_x_nxt      = lo_x_r;
    hi_x_nxt      = hi_x_r;
    lo_y_nxt      = lo_y_r;
    hi_y_nxt      = hi_y_r;
    bw_nxt        = bw_r;
    bh_nxt        = bh_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    cand_dx_nxt   = cand_dx_r;
    cand_dy_nxt   = cand_dy_r;
    ctr_dx_nxt    = ctr_dx_r;
    ctr_dy_nxt    = ctr_dy_r;
    best_dx_nxt   = best_dx_r;
    best_dy_nxt   = best_dy_r;
    min_sad_nxt   = min_sad_r;
    first_nxt     = first_r;
    step_nxt      = step_r;
    nb_nxt        = nb_r;
    acc_nxt       = s2_v_r ? (acc_r + ACW'(absd)) : acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_w_nxt = cfg_data;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_h_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.op == OP_START)) begin
          lo_x_nxt     = CW'(REACH) - CW'(in_data.block_x);
          lo_y_nxt     = CW'(REACH) - CW'(in_data.block_y);
          hi_x_nxt     = dx_diff + CW'(REACH - 1);
          hi_y_nxt     = dy_diff + CW'(REACH - 1);
          bw_nxt       = (dx_diff > $signed(CW'(BLOCK_SIZE))) ? BWW'(BLOCK_SIZE)
                                                              : BWW'(dx_diff);
          bh_nxt       = (dy_diff > $signed(CW'(BLOCK_SIZE))) ? BWW'(BLOCK_SIZE)
                                                              : BWW'(dy_diff);
          best_dx_nxt  = '0;
          best_dy_nxt  = '0;
          min_sad_nxt  = '0;
          cand_dx_nxt  = '0;
          cand_dy_nxt  = '0;
          ctr_dx_nxt   = '0;
          ctr_dy_nxt   = '0;
          first_nxt    = 1'b1;
          step_nxt     = SPW'(FIRST_STEP);
          nb_nxt       = '0;
          col_cnt_nxt  = '0;
          row_cnt_nxt  = '0;
          acc_nxt      = '0;
          if ((dx_diff <= 0) || (dy_diff <= 0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_col) begin
          col_cnt_nxt = '0;
          if (last_row) begin
            row_cnt_nxt = '0;
            state_nxt   = ST_DRAIN;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (better) begin
          best_dx_nxt  = cand_dx_r;
          best_dy_nxt  = cand_dy_r;
          min_sad_nxt  = acc_r;
        end
        acc_nxt   = '0;
        state_nxt = ST_SCAN;
        if (first_r) begin
          first_nxt  = 1'b0;
          nb_nxt     = '0;
          ctr_dx_nxt = nb_best_dx;
          ctr_dy_nxt = nb_best_dy;
        end else if (nb_r == 3'd7) begin
          step_nxt   = step_r >> 1;
          nb_nxt     = '0;
          ctr_dx_nxt = nb_best_dx;
          ctr_dy_nxt = nb_best_dy;
          if ((step_r >> 1) == '0) begin
            state_nxt = ST_FINISH;
          end
        end else begin
          nb_nxt = nb_r + 3'd1;
        end
        cand_dx_nxt = ctr_dx_nxt + offs(nb_x(nb_nxt), step_nxt);
        cand_dy_nxt = ctr_dy_nxt + offs(nb_y(nb_nxt), step_nxt);
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.best_dx  = VEC_W'(best_dx_r);
          out_word_nxt.best_dy  = VEC_W'(best_dy_r);
          out_word_nxt.min_sad  = (min_sad_r > SAD_SAT) ? SAD_W'(SAD_SAT)
                                                        : SAD_W'(min_sad_r);
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_w_r   <= FRAME_W_RESET;
      frame_h_r   <= FRAME_H_RESET;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      first_r     <= 1'b0;
      step_r      <= '0;
      nb_r        <= '0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      frame_w_r   <= frame_w_nxt;
      frame_h_r   <= frame_h_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= (state_r == ST_SCAN);
      s2_v_r      <= s1_v_r;
      first_r     <= first_nxt;
      step_r      <= step_nxt;
      nb_r        <= nb_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
    end
    lo_x_r     <= lo_x_nxt;
    hi_x_r     <= hi_x_nxt;
    lo_y_r     <= lo_y_nxt;
    hi_y_r     <= hi_y_nxt;
    bw_r       <= bw_nxt;
    bh_r       <= bh_nxt;
    cand_dx_r  <= cand_dx_nxt;
    cand_dy_r  <= cand_dy_nxt;
    ctr_dx_r   <= ctr_dx_nxt;
    ctr_dy_r   <= ctr_dy_nxt;
    best_dx_r  <= best_dx_nxt;
    best_dy_r  <= best_dy_nxt;
    min_sad_r  <= min_sad_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    s1_tx_r    <= tx_s;
    s1_ty_r    <= ty_s;
    s1_caddr_r <= CAW'(int'(row_cnt_r) * BLOCK_SIZE + int'(col_cnt_r));
    s2_ok_r    <= win_ok;
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_v_r && !s2_v_r))
    else $error("SAD pipeline busy while idle");

  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.op == OP_START)) |=> !in_ready)
    else $error("input taken during search");

  a_best_in_reach: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> ((best_dx_r <= REACH) && (best_dx_r >= -REACH) &&
                              (best_dy_r <= REACH) && (best_dy_r >= -REACH)))
    else $error("best vector beyond search reach");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((BWW'(col_cnt_r) < bw_r) && (BWW'(row_cnt_r) < bh_r)))
    else $error("scan counter beyond trimmed block");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result word raised outside finish");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-step block motion search.
// Fills the block and window stores, then runs directed words and random
// blocks of pixel loads closed by a search start. Frame sizes change between
// phases. A scoreboard predicts each best vector and SAD from the accepted
// words and compares them with the result words in order. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tsbms_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int CUR_SIDE     = BLOCK_SIZE_DEF;
  localparam int WIN_SIDE     = WINDOW_SIDE_DEF;
  localparam int REACH        = 2 * FIRST_STEP_DEF - 1;
  localparam int IDLE_PCT     = 36;
  localparam int STALL_LIMIT  = 60000;
  localparam int HOLD_CYCLES  = 15000;
  localparam int SETTLE       = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int BLOCKS       = 5;

  class motion_scoreboard;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    logic [PIX_W-1:0] block_px [CUR_SIDE*CUR_SIDE];
    logic [PIX_W-1:0] window_px [WIN_SIDE*WIN_SIDE];
    out_word_t        vectors_due [$];
    int               mismatches;
    int               words_in;
    int               searches;
    int               empty_blocks;
    int               trimmed_blocks;

    function new();
      frame_w        = FRAME_W_RESET;
      frame_h        = FRAME_H_RESET;
      mismatches     = 0;
      words_in       = 0;
      searches       = 0;
      empty_blocks   = 0;
      trimmed_blocks = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  frame_w = val;
        REG_FRAME_HEIGHT: frame_h = val;
        default: ;
      endcase
    endfunction

    function int clip_pos(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned vector_sad(int bx, int by, int bw, int bh, int dx, int dy);
      int unsigned acc;
      int          wr;
      int          wc;
      int          refv;
      int          diff;
      acc = 0;
      for (int r = 0; r < bh; r++) begin
        wr = clip_pos(by + r - dy, int'(frame_h) - 1) - by + REACH;
        for (int c = 0; c < bw; c++) begin
          wc = clip_pos(bx + c - dx, int'(frame_w) - 1) - bx + REACH;
          refv = 0;
          if (wr >= 0 && wr < WIN_SIDE && wc >= 0 && wc < WIN_SIDE)
            refv = int'(window_px[wr*WIN_SIDE + wc]);
          diff = int'(block_px[r*CUR_SIDE + c]) - refv;
          acc += (diff < 0) ? -diff : diff;
        end
      end
      return acc;
    endfunction

    function void note_input(in_word_t w);
      int          bx;
      int          by;
      int          bw;
      int          bh;
      int          cx;
      int          cy;
      int          dx;
      int          dy;
      int          best_dx;
      int          best_dy;
      int unsigned best;
      int unsigned s;
      out_word_t   want;
      words_in++;
      case (w.op)
        OP_LOAD_CUR: begin
          if (w.col < CUR_SIDE && w.row < CUR_SIDE)
            block_px[w.row*CUR_SIDE + w.col] = w.pixel;
        end
        OP_LOAD_REF: begin
          if (w.col < WIN_SIDE && w.row < WIN_SIDE)
            window_px[w.row*WIN_SIDE + w.col] = w.pixel;
        end
        OP_START: begin
          bx = int'(w.block_x);
          by = int'(w.block_y);
          bw = int'(frame_w) - bx;
          bh = int'(frame_h) - by;
          if (bw > CUR_SIDE) bw = CUR_SIDE;
          if (bh > CUR_SIDE) bh = CUR_SIDE;
          best_dx = 0;
          best_dy = 0;
          best    = 0;
          if (bw > 0 && bh > 0) begin
            if (bw < CUR_SIDE || bh < CUR_SIDE) trimmed_blocks++;
            best = vector_sad(bx, by, bw, bh, 0, 0);
            for (int stride = FIRST_STEP_DEF; stride >= 1; stride /= 2) begin
              cx = best_dx;
              cy = best_dy;
              for (int ny = -1; ny <= 1; ny++) begin
                for (int nx = -1; nx <= 1; nx++) begin
                  if (nx == 0 && ny == 0) continue;
                  dx = cx + nx * stride;
                  dy = cy + ny * stride;
                  s  = vector_sad(bx, by, bw, bh, dx, dy);
                  // strictly lower only: ties keep the earlier vector
                  if (s < best) begin
                    best    = s;
                    best_dx = dx;
                    best_dy = dy;
                  end
                end
              end
            end
          end else begin
            empty_blocks++;
          end
          want.best_dx = best_dx[VEC_W-1:0];
          want.best_dy = best_dy[VEC_W-1:0];
          want.min_sad = (best > 32'hFFFF) ? 16'hFFFF : best[SAD_W-1:0];
          vectors_due.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (vectors_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result dx %0d dy %0d sad %0d, expected none",
                 $time, got.best_dx, got.best_dy, got.min_sad);
        return;
      end
      want = vectors_due.pop_front();
      searches++;
      if (got.best_dx !== want.best_dx) begin
        mismatches++;
        $display("%0t: best_dx expected %0d, got %0d", $time, want.best_dx, got.best_dx);
      end
      if (got.best_dy !== want.best_dy) begin
        mismatches++;
        $display("%0t: best_dy expected %0d, got %0d", $time, want.best_dy, got.best_dy);
      end
      if (got.min_sad !== want.min_sad) begin
        mismatches++;
        $display("%0t: min_sad expected %0d, got %0d", $time, want.min_sad, got.min_sad);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  motion_scoreboard sb = new();
  bit steady_run = 1'b0;
  int hold_req   = 0;
  int cfg_writes = 0;

  three_step_block_motion_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_word_t noise_word();
    in_word_t w;
    w.op      = OP_SPARE;
    w.col     = POS_W'($urandom_range(0, 31));
    w.row     = POS_W'($urandom_range(0, 31));
    w.pixel   = PIX_W'($urandom_range(0, 255));
    w.block_x = ORG_W'($urandom_range(0, 4095));
    w.block_y = ORG_W'($urandom_range(0, 4095));
    return w;
  endfunction

  function automatic int pick_origin(int extent);
    int lim;
    int pick;
    lim  = (extent > 4096) ? 4096 : extent;
    pick = $urandom_range(0, 99);
    if (lim == 0 || pick < 15) return int'($urandom_range(0, 4095));
    if (pick < 40) return 16 * ((lim - 1) / 16);
    if (pick < 50) return int'($urandom_range(0, lim - 1));
    return 16 * int'($urandom_range(0, (lim - 1) / 16));
  endfunction

  task automatic send_word(in_word_t w);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  task automatic send_load(logic [OP_W-1:0] op, int col, int row, int pix);
    in_word_t w;
    w       = noise_word();
    w.op    = op;
    w.col   = POS_W'(col);
    w.row   = POS_W'(row);
    w.pixel = PIX_W'(pix);
    send_word(w);
  endtask

  task automatic send_start(int bx, int by);
    in_word_t w;
    w         = noise_word();
    w.op      = OP_START;
    w.block_x = ORG_W'(bx);
    w.block_y = ORG_W'(by);
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.vectors_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(int fw, int fh);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= DIM_W'(fw);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_FRAME_WIDTH, DIM_W'(fw));
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= DIM_W'(fh);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_FRAME_HEIGHT, DIM_W'(fh));
    cfg_valid  <= 1'b0;
    cfg_writes += 2;
  endtask

  task automatic run_block(int fw, int fh);
    int n;
    int kind;
    n = $urandom_range(0, 1);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45)
        send_load(OP_LOAD_CUR, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 255));
      else if (kind < 88)
        send_load(OP_LOAD_REF, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 255));
      else if (kind < 95)
        // off the block: dropped
        send_load(OP_LOAD_CUR, $urandom_range(0, 31), $urandom_range(16, 31),
                  $urandom_range(0, 255));
      else
        send_load(OP_SPARE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 255));
    end
    send_start(pick_origin(fw), pick_origin(fh));
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit take;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end else begin
        take = steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      out_ready <= take;
      @(posedge clk);
      if (out_valid && take) sb.check_result(out_data);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("FAIL");
    $finish;
  end

  initial begin
    int fw;
    int fh;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every store entry written once; bright block over a black window
    for (int r = 0; r < CUR_SIDE; r++)
      for (int c = 0; c < CUR_SIDE; c++)
        send_load(OP_LOAD_CUR, c, r, 255);
    for (int r = 0; r < WIN_SIDE; r++)
      for (int c = 0; c < WIN_SIDE; c++)
        send_load(OP_LOAD_REF, c, r, 0);

    // largest SAD, all candidates tied
    send_start(0, 0);
    send_load(OP_LOAD_CUR, 0, 0, 0);
    send_load(OP_LOAD_REF, REACH, REACH, 255);
    send_load(OP_LOAD_REF, 31, 31, 255);
    send_load(OP_LOAD_CUR, 16, 3, 170);
    send_load(OP_LOAD_CUR, 5, 31, 85);
    send_load(OP_LOAD_CUR, 31, 31, 17);
    send_load(OP_SPARE, 31, 31, 255);
    send_start(0, 0);
    send_start(4095, 4095);
    send_start(1920, 0);
    send_start(1904, 1072);
    send_start(15, 1079);
    send_start(1919, 1079);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin fw = 4096; fh = 4096; end
        1: begin fw = 1;    fh = 1;    end
        2: begin fw = 0;    fh = 4096; end
        3: begin fw = 8191; fh = 1;    end
        4: begin fw = 1920; fh = 1080; end
        8: begin fw = 4095; fh = 33;   end
        default: begin
          fw = $urandom_range(17, 300);
          fh = $urandom_range(17, 300);
        end
      endcase
      set_frame(fw, fh);
      steady_run = (ph == 0);
      // a later search queues behind a held result word and blocks the input
      if (ph == 4) hold_req = HOLD_CYCLES;
      repeat (BLOCKS) run_block(fw, fh);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Accepted %0d input words, checked %0d searches (%0d empty, %0d trimmed)",
             sb.words_in, sb.searches, sb.empty_blocks, sb.trimmed_blocks);
    $display("Wrote %0d frame registers over %0d frame sizes, with one long output hold-off",
             cfg_writes, PHASES + 1);
    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- three_step_block_motion_search.f -----
sv/tsbms_pkg.sv
sv/three_step_block_motion_search.sv
dv/tb_top.sv
